[rtl/vp8lf_pkg.sv]
`default_nettype none

package vp8lf_pkg;

    // Operation codes carried on s_tuser
    localparam logic [1:0] OP_SIMPLE = 2'd0;
    localparam logic [1:0] OP_MB     = 2'd1;
    localparam logic [1:0] OP_SUB    = 2'd2;

    // Filter weights for the macroblock-edge six-tap filter
    localparam int W27   = 27;
    localparam int W18   = 18;
    localparam int W9    = 9;
    localparam int ROUND = 63;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0] d;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        return d[8] ? 8'(-d) : d[7:0];
    endfunction

    function automatic logic signed [7:0] clamp_s8(input logic signed [10:0] v);
        if (v < -11'sd128) begin
            return -8'sd128;
        end else if (v > 11'sd127) begin
            return 8'sd127;
        end
        return v[7:0];
    endfunction

    function automatic logic [7:0] clip_pix(input logic signed [9:0] v);
        if (v < 10'sd0) begin
            return 8'd0;
        end else if (v > 10'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    typedef struct packed {
        logic [7:0] p2;
        logic [7:0] p1;
        logic [7:0] p0;
        logic [7:0] q0;
        logic [7:0] q1;
        logic [7:0] q2;
    } pix_t;

endpackage

`default_nettype wire

[rtl/vp8_edge_loop_filter_top.sv]
`default_nettype none
// VP8 edge loop filter, one pixel line per item.
// Input stream (s_*): one item is a line p3..q3 across a block edge plus the
// limits; s_tuser selects the mode (simple, macroblock edge, subblock edge).
// Output stream (m_*): the six pixels p2..q2 after filtering on m_tdata and
// a was-filtered flag on m_tuser. Untouched pixels pass through unchanged.
// Pipeline: four register stages from input acceptance to m_tvalid:
// difference/abs, threshold tests and filter value, tap weights and
// adjustments, then add-and-clamp into the output register.
// Throughput: one item per cycle unless stalled; the pipe holds up to four items.
// Stall: all stages advance together only while the output register is empty
// or being taken. When m_tready is low with a result waiting, the whole
// pipeline holds and s_tready drops, so no item is lost or repeated.
// Reset: aresetn (synchronous, active low) clears all stage valid bits; the
// block accepts items in the first cycle after reset is released.
module vp8_edge_loop_filter_top (
    input  wire         aclk,
    input  wire         aresetn,
    // s_tdata fields, low to high: pix_p3, pix_p2, pix_p1, pix_p0, pix_q0,
    // pix_q1, pix_q2, pix_q3, e_lim[7:0], i_lim[5:0], hev_thr[1:0]
    input  wire  [79:0] s_tdata,
    // s_tuser fields: operation[1:0]
    input  wire  [1:0]  s_tuser,
    input  wire         s_tvalid,
    output logic        s_tready,
    // m_tdata fields, low to high: out_p2, out_p1, out_p0, out_q0, out_q1, out_q2
    output logic [47:0] m_tdata,
    // m_tuser fields: was_filtered
    output logic        m_tuser,
    output logic        m_tvalid,
    input  wire         m_tready
);
    import vp8lf_pkg::*;

    logic adv;

    // ---------------- input unpack ----------------
    logic [7:0] in_p3, in_p2, in_p1, in_p0, in_q0, in_q1, in_q2, in_q3;
    logic [7:0] in_e;
    logic [5:0] in_i;
    logic [1:0] in_thr;

    assign in_p3  = s_tdata[7:0];
    assign in_p2  = s_tdata[15:8];
    assign in_p1  = s_tdata[23:16];
    assign in_p0  = s_tdata[31:24];
    assign in_q0  = s_tdata[39:32];
    assign in_q1  = s_tdata[47:40];
    assign in_q2  = s_tdata[55:48];
    assign in_q3  = s_tdata[63:56];
    assign in_e   = s_tdata[71:64];
    assign in_i   = s_tdata[77:72];
    assign in_thr = s_tdata[79:78];

    // whole pipe moves when the output slot is free or draining
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: differences ----------------
    logic              v1_reg;
    pix_t              px1_reg;
    logic [1:0]        op1_reg;
    logic [7:0]        e1_reg;
    logic [5:0]        i1_reg;
    logic [1:0]        thr1_reg;
    logic [7:0]        d_p0q0_reg, d_p1q1_reg;
    logic [7:0]        d_p3p2_reg, d_p2p1_reg, d_p1p0_reg;
    logic [7:0]        d_q3q2_reg, d_q2q1_reg, d_q1q0_reg;
    logic signed [8:0] dq0p0_reg;   // q0 - p0
    logic signed [7:0] c_reg;       // clamp_s8(p1 - q1)

    logic signed [8:0] dq0p0_next;
    logic signed [8:0] dp1q1_next;

    assign dq0p0_next = $signed({1'b0, in_q0}) - $signed({1'b0, in_p0});
    assign dp1q1_next = $signed({1'b0, in_p1}) - $signed({1'b0, in_q1});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
        if (adv) begin
            px1_reg    <= '{p2: in_p2, p1: in_p1, p0: in_p0, q0: in_q0, q1: in_q1, q2: in_q2};
            op1_reg    <= s_tuser;
            e1_reg     <= in_e;
            i1_reg     <= in_i;
            thr1_reg   <= in_thr;
            d_p0q0_reg <= abs_diff(in_p0, in_q0);
            d_p1q1_reg <= abs_diff(in_p1, in_q1);
            d_p3p2_reg <= abs_diff(in_p3, in_p2);
            d_p2p1_reg <= abs_diff(in_p2, in_p1);
            d_p1p0_reg <= abs_diff(in_p1, in_p0);
            d_q3q2_reg <= abs_diff(in_q3, in_q2);
            d_q2q1_reg <= abs_diff(in_q2, in_q1);
            d_q1q0_reg <= abs_diff(in_q1, in_q0);
            dq0p0_reg  <= dq0p0_next;
            c_reg      <= clamp_s8(11'(dp1q1_next));
        end
    end

    // ---------------- stage 2: thresholds, filter value ----------------
    logic              v2_reg;
    pix_t              px2_reg;
    logic              pass2_reg;
    logic              wide2_reg;   // 27/18/9 filter
    logic              outer2_reg;  // common filter uses outer taps
    logic signed [7:0] w2_reg;

    logic [9:0]         edge_sum;
    logic [9:0]         edge_lim;
    logic               edge_ok;
    logic               inner_ok;
    logic               hev;
    logic               is_simple, is_normal;
    logic               pass_next, wide_next, outer_next;
    logic signed [10:0] base3;
    logic signed [10:0] w_sum;

    always_comb begin
        is_simple = (op1_reg == OP_SIMPLE);
        is_normal = (op1_reg == OP_MB) || (op1_reg == OP_SUB);
        edge_sum  = {1'b0, d_p0q0_reg, 1'b0} + 10'(d_p1q1_reg >> 1);
        edge_lim  = is_simple ? 10'(e1_reg) : ({1'b0, e1_reg, 1'b0} + 10'(i1_reg));
        edge_ok   = (edge_sum <= edge_lim);
        inner_ok  = (d_p3p2_reg <= 8'(i1_reg)) && (d_p2p1_reg <= 8'(i1_reg))
                 && (d_p1p0_reg <= 8'(i1_reg)) && (d_q3q2_reg <= 8'(i1_reg))
                 && (d_q2q1_reg <= 8'(i1_reg)) && (d_q1q0_reg <= 8'(i1_reg));
        hev       = (d_p1p0_reg > 8'(thr1_reg)) || (d_q1q0_reg > 8'(thr1_reg));
        pass_next = is_simple ? edge_ok : (is_normal && edge_ok && inner_ok);
        wide_next = (op1_reg == OP_MB) && !hev;
        outer_next = (op1_reg == OP_SUB) ? hev : 1'b1;
        base3     = 11'(dq0p0_reg) + 11'(dq0p0_reg) + 11'(dq0p0_reg);
        w_sum     = outer_next ? (base3 + 11'(c_reg)) : base3;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            px2_reg    <= px1_reg;
            pass2_reg  <= pass_next;
            wide2_reg  <= wide_next;
            outer2_reg <= outer_next;
            w2_reg     <= clamp_s8(w_sum);
        end
    end

    // ---------------- stage 3: tap weights, adjustments ----------------
    logic              v3_reg;
    pix_t              px3_reg;
    logic              pass3_reg;
    logic signed [8:0] adj_p2_reg, adj_p1_reg, adj_p0_reg;
    logic signed [8:0] adj_q0_reg, adj_q1_reg, adj_q2_reg;

    logic signed [13:0] t27, t18, t9;
    logic signed [13:0] s27, s18, s9;
    logic signed [7:0]  a4, a3;
    logic signed [4:0]  f1, f2;
    logic signed [5:0]  h_sum;
    logic signed [4:0]  h;
    logic signed [8:0]  ap2, ap1, ap0, aq0, aq1, aq2;

    always_comb begin
        t27 = 14'(W27 + 0) * 14'(w2_reg) + 14'(ROUND);
        t18 = 14'(W18 + 0) * 14'(w2_reg) + 14'(ROUND);
        t9  = 14'(W9 + 0)  * 14'(w2_reg) + 14'(ROUND);
        s27 = t27 >>> 7;
        s18 = t18 >>> 7;
        s9  = t9 >>> 7;
        a4  = clamp_s8(11'(w2_reg) + 11'sd4);
        a3  = clamp_s8(11'(w2_reg) + 11'sd3);
        f1  = 5'(a4 >>> 3);
        f2  = 5'(a3 >>> 3);
        h_sum = 6'(f1) + 6'sd1;
        h     = 5'(h_sum >>> 1);
        ap2 = '0; ap1 = '0; ap0 = '0; aq0 = '0; aq1 = '0; aq2 = '0;
        if (pass2_reg && wide2_reg) begin
            ap0 = 9'(s27);
            aq0 = -9'(s27);
            ap1 = 9'(s18);
            aq1 = -9'(s18);
            ap2 = 9'(s9);
            aq2 = -9'(s9);
        end else if (pass2_reg) begin
            ap0 = 9'(f2);
            aq0 = -9'(f1);
            if (!outer2_reg) begin
                ap1 = 9'(h);
                aq1 = -9'(h);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            px3_reg    <= px2_reg;
            pass3_reg  <= pass2_reg;
            adj_p2_reg <= ap2;
            adj_p1_reg <= ap1;
            adj_p0_reg <= ap0;
            adj_q0_reg <= aq0;
            adj_q1_reg <= aq1;
            adj_q2_reg <= aq2;
        end
    end

    // ---------------- stage 4: apply and clamp into output register ----------
    logic        m_tvalid_reg;
    pix_t        out_reg;
    logic        filt_reg;
    pix_t        out_next;

    always_comb begin
        out_next.p2 = clip_pix($signed({2'b00, px3_reg.p2}) + 10'(adj_p2_reg));
        out_next.p1 = clip_pix($signed({2'b00, px3_reg.p1}) + 10'(adj_p1_reg));
        out_next.p0 = clip_pix($signed({2'b00, px3_reg.p0}) + 10'(adj_p0_reg));
        out_next.q0 = clip_pix($signed({2'b00, px3_reg.q0}) + 10'(adj_q0_reg));
        out_next.q1 = clip_pix($signed({2'b00, px3_reg.q1}) + 10'(adj_q1_reg));
        out_next.q2 = clip_pix($signed({2'b00, px3_reg.q2}) + 10'(adj_q2_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= v3_reg;
        end
        if (adv) begin
            out_reg  <= out_next;
            filt_reg <= pass3_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = filt_reg;
    assign m_tdata  = {out_reg.q2, out_reg.q1, out_reg.q0,
                       out_reg.p0, out_reg.p1, out_reg.p2};

endmodule

`default_nettype wire
